>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted key table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define SKT_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("Assertion failed.");

// A condition that, once seen, implies another in the next cycle.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed.");

`endif

>>> src/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Constants, operation codes and the command and status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

   localparam int DEPTH_DEF       = 256;
   localparam int HANDLE_BITS_DEF = 16;

   localparam int KEY_W    = 32;
   localparam int MODE_W   = 4;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 5;
   localparam int RSEL_W   = 3;

   localparam logic [MODE_W-1:0] MODE_INSERT        = 4'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT_UNIQUE = 4'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE        = 4'd2;
   localparam logic [MODE_W-1:0] MODE_FIRST         = 4'd3;
   localparam logic [MODE_W-1:0] MODE_LAST          = 4'd4;
   localparam logic [MODE_W-1:0] MODE_PREV          = 4'd5;
   localparam logic [MODE_W-1:0] MODE_NEXT          = 4'd6;
   localparam logic [MODE_W-1:0] MODE_CURRENT       = 4'd7;
   localparam logic [MODE_W-1:0] MODE_SEEK_TO       = 4'd8;
   localparam logic [MODE_W-1:0] MODE_FIND          = 4'd9;
   localparam logic [MODE_W-1:0] MODE_CLEAR         = 4'd10;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_W-1:0] OP_SRCH_INIT = 5'd2;
   localparam logic [OP_W-1:0] OP_SRCH_STEP = 5'd3;
   localparam logic [OP_W-1:0] OP_CURSOR    = 5'd4;
   localparam logic [OP_W-1:0] OP_REM_GET   = 5'd5;
   localparam logic [OP_W-1:0] OP_REM_END   = 5'd6;
   localparam logic [OP_W-1:0] OP_SHIFT_UP  = 5'd7;
   localparam logic [OP_W-1:0] OP_SHIFT_DN  = 5'd8;
   localparam logic [OP_W-1:0] OP_FIND_SET  = 5'd9;
   localparam logic [OP_W-1:0] OP_DUP       = 5'd10;
   localparam logic [OP_W-1:0] OP_REPL      = 5'd11;
   localparam logic [OP_W-1:0] OP_FULL      = 5'd12;
   localparam logic [OP_W-1:0] OP_PTR_CNT   = 5'd13;
   localparam logic [OP_W-1:0] OP_INS_PUT   = 5'd14;
   localparam logic [OP_W-1:0] OP_FIN       = 5'd15;
   localparam logic [OP_W-1:0] OP_EMIT      = 5'd16;

   localparam logic [RSEL_W-1:0] RS_CUR  = 3'd0;
   localparam logic [RSEL_W-1:0] RS_MID  = 3'd1;
   localparam logic [RSEL_W-1:0] RS_LO   = 3'd2;
   localparam logic [RSEL_W-1:0] RS_PTRM = 3'd3;
   localparam logic [RSEL_W-1:0] RS_PTRP = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [RSEL_W-1:0] rsel;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              repl;
      logic              cur_valid;
      logic              srch_more;
      logic              hit;
      logic              full;
      logic              ins_more;
      logic              rem_more;
      logic              out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> src/sorted_key_table_with_cursor.sv
// Find and insert run a binary search of at most log2(DEPTH)+1 steps; an
// insert that is not refused, full or replacing, and a remove with a valid
// cursor then move the entries behind the position one place each. One item
// is worked on at a time; the single read port of the entry memory sets the
// pace of the search and the shift. Reset empties the table and invalidates
// the cursor at once; no sweep.
// ----------------------------------------------------------------------------
// Sorted key table with cursor
// Entries of key and handle kept in ascending key order in a memory, with a
// cursor, served by a controller and a datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_with_cursor #(
   parameter int DEPTH       = skt_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [skt_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [skt_pkg::KEY_W-1:0]    req_key,
   input  wire logic [HANDLE_BITS-1:0]       req_handle,
   input  wire logic                         req_replace,
   input  wire logic [skt_pkg::POS_W-1:0]    req_position,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid_res,
   output logic [skt_pkg::KEY_W-1:0]         rsp_entry_key,
   output logic [HANDLE_BITS-1:0]            rsp_entry_handle,
   output logic [skt_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_freed,
   output logic [HANDLE_BITS-1:0]            rsp_freed_handle,
   output logic [CW-1:0]                     rsp_count
);

   skt_pkg::cmd_type cmd;
   skt_pkg::sts_type sts;

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   skt_dpath #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_handle       (req_handle),
      .req_replace      (req_replace),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_entry_key    (rsp_entry_key),
      .rsp_entry_handle (rsp_entry_handle),
      .rsp_status       (rsp_status),
      .rsp_freed        (rsp_freed),
      .rsp_freed_handle (rsp_freed_handle),
      .rsp_count        (rsp_count)
   );

endmodule

`default_nettype wire

>>> src/skt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences the search, shift, cursor and result steps of one item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module skt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire skt_pkg::sts_type sts,
   output skt_pkg::cmd_type      cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SRCH_RD  = 4'd2;
   localparam logic [3:0] S_SRCH_CMP = 4'd3;
   localparam logic [3:0] S_CHECK    = 4'd4;
   localparam logic [3:0] S_INS_RD   = 4'd5;
   localparam logic [3:0] S_INS_WR   = 4'd6;
   localparam logic [3:0] S_REM_GET  = 4'd7;
   localparam logic [3:0] S_REM_RD   = 4'd8;
   localparam logic [3:0] S_REM_WR   = 4'd9;
   localparam logic [3:0] S_FIN_RD   = 4'd10;
   localparam logic [3:0] S_FIN_GET  = 4'd11;
   localparam logic [3:0] S_RES      = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = skt_pkg::OP_NONE;
      cmd.rsel = skt_pkg::RS_CUR;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = skt_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.mode)
               skt_pkg::MODE_INSERT, skt_pkg::MODE_INSERT_UNIQUE,
               skt_pkg::MODE_FIND: begin
                  cmd.op   = skt_pkg::OP_SRCH_INIT;
                  state_in = S_SRCH_RD;
               end
               skt_pkg::MODE_REMOVE: begin
                  if (sts.cur_valid) begin
                     cmd.rsel = skt_pkg::RS_CUR;
                     state_in = S_REM_GET;
                  end else begin
                     state_in = S_RES;
                  end
               end
               default: begin
                  cmd.op   = skt_pkg::OP_CURSOR;
                  state_in = S_FIN_RD;
               end
            endcase
         end
         S_SRCH_RD: begin
            if (sts.srch_more) begin
               cmd.rsel = skt_pkg::RS_MID;
               state_in = S_SRCH_CMP;
            end else begin
               cmd.rsel = skt_pkg::RS_LO;
               state_in = S_CHECK;
            end
         end
         S_SRCH_CMP: begin
            cmd.op   = skt_pkg::OP_SRCH_STEP;
            state_in = S_SRCH_RD;
         end
         S_CHECK: begin
            if (sts.mode == skt_pkg::MODE_FIND) begin
               cmd.op   = skt_pkg::OP_FIND_SET;
               state_in = S_FIN_RD;
            end else if (sts.mode == skt_pkg::MODE_INSERT_UNIQUE && sts.hit) begin
               cmd.op   = sts.repl ? skt_pkg::OP_REPL : skt_pkg::OP_DUP;
               state_in = S_RES;
            end else if (sts.full) begin
               cmd.op   = skt_pkg::OP_FULL;
               state_in = S_RES;
            end else begin
               cmd.op   = skt_pkg::OP_PTR_CNT;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (sts.ins_more) begin
               cmd.rsel = skt_pkg::RS_PTRM;
               state_in = S_INS_WR;
            end else begin
               cmd.op   = skt_pkg::OP_INS_PUT;
               state_in = S_RES;
            end
         end
         S_INS_WR: begin
            cmd.op   = skt_pkg::OP_SHIFT_DN;
            state_in = S_INS_RD;
         end
         S_REM_GET: begin
            cmd.op   = skt_pkg::OP_REM_GET;
            state_in = S_REM_RD;
         end
         S_REM_RD: begin
            if (sts.rem_more) begin
               cmd.rsel = skt_pkg::RS_PTRP;
               state_in = S_REM_WR;
            end else begin
               cmd.op   = skt_pkg::OP_REM_END;
               state_in = S_RES;
            end
         end
         S_REM_WR: begin
            cmd.op   = skt_pkg::OP_SHIFT_UP;
            state_in = S_REM_RD;
         end
         S_FIN_RD: begin
            cmd.rsel = skt_pkg::RS_CUR;
            state_in = S_FIN_GET;
         end
         S_FIN_GET: begin
            cmd.op   = skt_pkg::OP_FIN;
            state_in = S_RES;
         end
         S_RES: begin
            if (sts.out_free) begin
               cmd.op   = skt_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SKT_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && !req_stall, state_ff == S_DISPATCH)
   `SKT_ASSERT_NEXT(a_result_held, clock, reset, state_ff == S_RES && !sts.out_free, state_ff == S_RES)

endmodule

`default_nettype wire

>>> src/skt_dpath.sv
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Entry memory, search bounds, shift pointer, cursor, count and result
// registers, driven by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module skt_dpath #(
   parameter int DEPTH       = skt_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire skt_pkg::cmd_type             cmd,
   output skt_pkg::sts_type                  sts,
   input  wire logic [skt_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [skt_pkg::KEY_W-1:0]    req_key,
   input  wire logic [HANDLE_BITS-1:0]       req_handle,
   input  wire logic                         req_replace,
   input  wire logic [skt_pkg::POS_W-1:0]    req_position,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid_res,
   output logic [skt_pkg::KEY_W-1:0]         rsp_entry_key,
   output logic [HANDLE_BITS-1:0]            rsp_entry_handle,
   output logic [skt_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_freed,
   output logic [HANDLE_BITS-1:0]            rsp_freed_handle,
   output logic [CW-1:0]                     rsp_count
);

   localparam int EW = skt_pkg::KEY_W + HANDLE_BITS;
   localparam int PW = (CW > skt_pkg::POS_W) ? CW : skt_pkg::POS_W;

   logic [EW-1:0] store_ff [DEPTH];
   logic [EW-1:0] rdata_ff;

   logic [skt_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [skt_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_BITS-1:0]       handle_ff, handle_in;
   logic                         repl_ff, repl_in;
   logic [skt_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [CW-1:0]                lo_ff, lo_in;
   logic [CW-1:0]                hi_ff, hi_in;
   logic [CW-1:0]                ptr_ff, ptr_in;
   logic [skt_pkg::KEY_W-1:0]    okey_ff, okey_in;
   logic [HANDLE_BITS-1:0]       ohandle_ff, ohandle_in;
   logic [skt_pkg::STATUS_W-1:0] ostatus_ff, ostatus_in;
   logic                         ofreed_ff, ofreed_in;
   logic [HANDLE_BITS-1:0]       ofh_ff, ofh_in;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cur_idx_ff, cur_idx_in;
   logic          cur_valid_ff, cur_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic                         rsp_valid_res_ff, rsp_valid_res_in;
   logic [skt_pkg::KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [HANDLE_BITS-1:0]       rsp_handle_ff, rsp_handle_in;
   logic [skt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_freed_ff, rsp_freed_in;
   logic [HANDLE_BITS-1:0]       rsp_fh_ff, rsp_fh_in;
   logic [CW-1:0]                rsp_count_ff, rsp_count_in;

   logic [CW:0]                  msum;
   logic [CW-1:0]                mid;
   logic [CW-1:0]                cm1;
   logic [PW-1:0]                pos_x;
   logic [PW-1:0]                cm1_x;
   logic [skt_pkg::KEY_W-1:0]    rkey;
   logic [HANDLE_BITS-1:0]       rhandle;
   logic                         hit;
   logic [AW-1:0]                raddr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [EW-1:0]                wr_data;

   assign msum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = msum[CW:1];
   assign cm1     = count_ff - CW'(1);
   assign pos_x   = PW'(pos_ff);
   assign cm1_x   = PW'(cm1);
   assign rkey    = rdata_ff[EW-1:HANDLE_BITS];
   assign rhandle = rdata_ff[HANDLE_BITS-1:0];
   assign hit     = (lo_ff < count_ff) && (rkey == key_ff);

   always_comb begin
      case (cmd.rsel)
         skt_pkg::RS_MID:  raddr = mid[AW-1:0];
         skt_pkg::RS_LO:   raddr = lo_ff[AW-1:0];
         skt_pkg::RS_PTRM: raddr = AW'(ptr_ff - CW'(1));
         skt_pkg::RS_PTRP: raddr = AW'(ptr_ff + CW'(1));
         default:          raddr = cur_idx_ff;
      endcase
   end

   assign sts.mode      = mode_ff;
   assign sts.repl      = repl_ff;
   assign sts.cur_valid = cur_valid_ff;
   assign sts.srch_more = lo_ff < hi_ff;
   assign sts.hit       = hit;
   assign sts.full      = count_ff == CW'(DEPTH);
   assign sts.ins_more  = ptr_ff > lo_ff;
   assign sts.rem_more  = (ptr_ff + CW'(1)) < count_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mode_in          = mode_ff;
      key_in           = key_ff;
      handle_in        = handle_ff;
      repl_in          = repl_ff;
      pos_in           = pos_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      ptr_in           = ptr_ff;
      okey_in          = okey_ff;
      ohandle_in       = ohandle_ff;
      ostatus_in       = ostatus_ff;
      ofreed_in        = ofreed_ff;
      ofh_in           = ofh_ff;
      count_in         = count_ff;
      cur_idx_in       = cur_idx_ff;
      cur_valid_in     = cur_valid_ff;
      rsp_valid_res_in = rsp_valid_res_ff;
      rsp_key_in       = rsp_key_ff;
      rsp_handle_in    = rsp_handle_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_freed_in     = rsp_freed_ff;
      rsp_fh_in        = rsp_fh_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      wr_en            = 1'b0;
      wr_addr          = lo_ff[AW-1:0];
      wr_data          = {key_ff, handle_ff};
      case (cmd.op)
         skt_pkg::OP_LOAD: begin
            mode_in    = req_mode;
            key_in     = req_key;
            handle_in  = req_handle;
            repl_in    = req_replace;
            pos_in     = req_position;
            okey_in    = '0;
            ohandle_in = '0;
            ostatus_in = skt_pkg::ST_OK;
            ofreed_in  = 1'b0;
            ofh_in     = '0;
         end
         skt_pkg::OP_SRCH_INIT: begin
            lo_in = '0;
            hi_in = count_ff;
            if (mode_ff != skt_pkg::MODE_FIND) begin
               okey_in    = key_ff;
               ohandle_in = handle_ff;
            end
         end
         skt_pkg::OP_SRCH_STEP: begin
            if (rkey < key_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
         end
         skt_pkg::OP_CURSOR: begin
            case (mode_ff)
               skt_pkg::MODE_FIRST: begin
                  cur_idx_in   = '0;
                  cur_valid_in = count_ff != '0;
               end
               skt_pkg::MODE_LAST: begin
                  cur_idx_in   = (count_ff != '0) ? cm1[AW-1:0] : '0;
                  cur_valid_in = count_ff != '0;
               end
               skt_pkg::MODE_PREV: begin
                  if (cur_valid_ff) begin
                     if (cur_idx_ff == '0) begin
                        cur_valid_in = 1'b0;
                     end else begin
                        cur_idx_in = cur_idx_ff - AW'(1);
                     end
                  end
               end
               skt_pkg::MODE_NEXT: begin
                  if (cur_valid_ff && (CW'(cur_idx_ff) + CW'(1)) < count_ff) begin
                     cur_idx_in = cur_idx_ff + AW'(1);
                  end else begin
                     cur_valid_in = 1'b0;
                  end
               end
               skt_pkg::MODE_SEEK_TO: begin
                  if (count_ff == '0) begin
                     cur_valid_in = 1'b0;
                  end else begin
                     cur_idx_in   = (pos_x < cm1_x) ? pos_x[AW-1:0] : cm1[AW-1:0];
                     cur_valid_in = 1'b1;
                  end
               end
               skt_pkg::MODE_CLEAR: begin
                  count_in     = '0;
                  cur_idx_in   = '0;
                  cur_valid_in = 1'b0;
               end
               default: begin
                  cur_valid_in = cur_valid_ff;
               end
            endcase
         end
         skt_pkg::OP_REM_GET: begin
            okey_in    = rkey;
            ohandle_in = rhandle;
            ptr_in     = CW'(cur_idx_ff);
         end
         skt_pkg::OP_REM_END: begin
            count_in = cm1;
            if (CW'(cur_idx_ff) >= cm1) begin
               cur_valid_in = 1'b0;
            end
         end
         skt_pkg::OP_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rdata_ff;
            ptr_in  = ptr_ff + CW'(1);
         end
         skt_pkg::OP_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rdata_ff;
            ptr_in  = ptr_ff - CW'(1);
         end
         skt_pkg::OP_FIND_SET: begin
            cur_valid_in = hit;
            if (hit) begin
               cur_idx_in = lo_ff[AW-1:0];
            end
         end
         skt_pkg::OP_DUP: begin
            ostatus_in = skt_pkg::ST_DUP;
         end
         skt_pkg::OP_REPL: begin
            wr_en        = 1'b1;
            wr_data      = {rkey, handle_ff};
            ofreed_in    = 1'b1;
            ofh_in       = rhandle;
            cur_idx_in   = lo_ff[AW-1:0];
            cur_valid_in = 1'b1;
         end
         skt_pkg::OP_FULL: begin
            ostatus_in = skt_pkg::ST_FULL;
         end
         skt_pkg::OP_PTR_CNT: begin
            ptr_in = count_ff;
         end
         skt_pkg::OP_INS_PUT: begin
            wr_en        = 1'b1;
            count_in     = count_ff + CW'(1);
            cur_idx_in   = lo_ff[AW-1:0];
            cur_valid_in = 1'b1;
         end
         skt_pkg::OP_FIN: begin
            if (cur_valid_ff) begin
               okey_in    = rkey;
               ohandle_in = rhandle;
            end
         end
         skt_pkg::OP_EMIT: begin
            rsp_valid_in     = 1'b1;
            rsp_valid_res_in = cur_valid_ff;
            rsp_key_in       = okey_ff;
            rsp_handle_in    = ohandle_ff;
            rsp_status_in    = ostatus_ff;
            rsp_freed_in     = ofreed_ff;
            rsp_fh_in        = ofh_ff;
            rsp_count_in     = count_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= store_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cur_idx_ff   <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cur_idx_ff   <= cur_idx_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      key_ff           <= key_in;
      handle_ff        <= handle_in;
      repl_ff          <= repl_in;
      pos_ff           <= pos_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      ptr_ff           <= ptr_in;
      okey_ff          <= okey_in;
      ohandle_ff       <= ohandle_in;
      ostatus_ff       <= ostatus_in;
      ofreed_ff        <= ofreed_in;
      ofh_ff           <= ofh_in;
      rsp_valid_res_ff <= rsp_valid_res_in;
      rsp_key_ff       <= rsp_key_in;
      rsp_handle_ff    <= rsp_handle_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_freed_ff     <= rsp_freed_in;
      rsp_fh_ff        <= rsp_fh_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_valid_res    = rsp_valid_res_ff;
   assign rsp_entry_key    = rsp_key_ff;
   assign rsp_entry_handle = rsp_handle_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_freed        = rsp_freed_ff;
   assign rsp_freed_handle = rsp_fh_ff;
   assign rsp_count        = rsp_count_ff;

   `SKT_ASSERT(a_cursor_in_range, clock, reset, !cur_valid_ff || (CW'(cur_idx_ff) < count_ff))
   `SKT_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `SKT_ASSERT_NEXT(a_insert_count, clock, reset, cmd.op == skt_pkg::OP_INS_PUT, count_ff == $past(count_ff) + CW'(1))

endmodule

`default_nettype wire

>>> test/sorted_key_table_with_cursor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table with cursor testbench
// Drives table and cursor commands with random gaps. It predicts each
// response from its own copy of the table and cursor, and compares every
// response field. The receiver stalls at random and once holds off for a
// long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_with_cursor_tb;

   localparam int DEPTH      = skt_pkg::DEPTH_DEF;
   localparam int HB         = skt_pkg::HANDLE_BITS_DEF;
   localparam int CW         = $clog2(DEPTH + 1);
   localparam int KW         = skt_pkg::KEY_W;
   localparam int MW         = skt_pkg::MODE_W;
   localparam int PSW        = skt_pkg::POS_W;
   localparam int SW         = skt_pkg::STATUS_W;
   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 400;

   typedef struct packed {
      logic          valid_res;
      logic [KW-1:0] entry_key;
      logic [HB-1:0] entry_handle;
      logic [SW-1:0] status;
      logic          freed;
      logic [HB-1:0] freed_handle;
      logic [CW-1:0] count;
   } outcome_type;

   class table_scoreboard;
      logic [KW-1:0] keys [DEPTH];
      logic [HB-1:0] handles [DEPTH];
      int unsigned   entries;
      int unsigned   cur_idx;
      bit            cur_valid;
      outcome_type   awaited [$];
      int            errors;

      function int unsigned first_not_below(logic [KW-1:0] k);
         int unsigned i;
         for (i = 0; i < entries; i++) begin
            if (keys[i] >= k) break;
         end
         return i;
      endfunction

      function void note_request(logic [MW-1:0] mode, logic [KW-1:0] key,
                                 logic [HB-1:0] hdl, logic repl,
                                 logic [PSW-1:0] pos);
         outcome_type o;
         bit at_cursor;
         int unsigned p;
         o = '0;
         at_cursor = 1;
         case (mode)
            skt_pkg::MODE_INSERT, skt_pkg::MODE_INSERT_UNIQUE: begin
               at_cursor = 0;
               o.entry_key = key;
               o.entry_handle = hdl;
               p = first_not_below(key);
               if (mode == skt_pkg::MODE_INSERT_UNIQUE && p < entries
                   && keys[p] == key) begin
                  if (!repl) begin
                     o.status = skt_pkg::ST_DUP;
                  end else begin
                     o.freed = 1;
                     o.freed_handle = handles[p];
                     handles[p] = hdl;
                     cur_idx = p;
                     cur_valid = 1;
                  end
               end else if (entries >= DEPTH) begin
                  o.status = skt_pkg::ST_FULL;
               end else begin
                  for (int unsigned i = entries; i > p; i--) begin
                     keys[i] = keys[i-1];
                     handles[i] = handles[i-1];
                  end
                  keys[p] = key;
                  handles[p] = hdl;
                  entries++;
                  cur_idx = p;
                  cur_valid = 1;
               end
            end
            skt_pkg::MODE_REMOVE: begin
               at_cursor = 0;
               if (cur_valid && cur_idx < entries) begin
                  o.entry_key = keys[cur_idx];
                  o.entry_handle = handles[cur_idx];
                  for (int unsigned i = cur_idx; i + 1 < entries; i++) begin
                     keys[i] = keys[i+1];
                     handles[i] = handles[i+1];
                  end
                  entries--;
                  if (cur_idx >= entries) cur_valid = 0;
               end else begin
                  cur_valid = 0;
               end
            end
            skt_pkg::MODE_FIRST: begin
               cur_idx = 0;
               cur_valid = entries > 0;
            end
            skt_pkg::MODE_LAST: begin
               cur_idx = entries > 0 ? entries - 1 : 0;
               cur_valid = entries > 0;
            end
            skt_pkg::MODE_PREV: begin
               if (cur_valid) begin
                  if (cur_idx == 0) cur_valid = 0;
                  else cur_idx--;
               end
            end
            skt_pkg::MODE_NEXT: begin
               if (cur_valid && cur_idx + 1 < entries) cur_idx++;
               else cur_valid = 0;
            end
            skt_pkg::MODE_SEEK_TO: begin
               if (entries == 0) begin
                  cur_valid = 0;
               end else begin
                  cur_idx = pos < entries - 1 ? pos : entries - 1;
                  cur_valid = 1;
               end
            end
            skt_pkg::MODE_FIND: begin
               p = first_not_below(key);
               if (p < entries && keys[p] == key) begin
                  cur_idx = p;
                  cur_valid = 1;
               end else begin
                  cur_valid = 0;
               end
            end
            skt_pkg::MODE_CLEAR: begin
               entries = 0;
               cur_idx = 0;
               cur_valid = 0;
            end
            default: ;
         endcase
         if (cur_valid && cur_idx >= entries) cur_valid = 0;
         if (at_cursor && cur_valid) begin
            o.entry_key = keys[cur_idx];
            o.entry_handle = handles[cur_idx];
         end
         o.valid_res = cur_valid;
         o.count = entries[CW-1:0];
         awaited.push_back(o);
      endfunction

      task report(string msg);
         $display("Mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(outcome_type got);
         outcome_type e;
         if (awaited.size() == 0) begin
            report("response with none expected");
            return;
         end
         e = awaited.pop_front();
         if (got.valid_res !== e.valid_res)
            report($sformatf("valid_res %0h, expected %0h", got.valid_res, e.valid_res));
         if (got.entry_key !== e.entry_key)
            report($sformatf("entry_key %0h, expected %0h", got.entry_key, e.entry_key));
         if (got.entry_handle !== e.entry_handle)
            report($sformatf("entry_handle %0h, expected %0h",
                             got.entry_handle, e.entry_handle));
         if (got.status !== e.status)
            report($sformatf("status %0h, expected %0h", got.status, e.status));
         if (got.freed !== e.freed)
            report($sformatf("freed %0h, expected %0h", got.freed, e.freed));
         if (got.freed_handle !== e.freed_handle)
            report($sformatf("freed_handle %0h, expected %0h",
                             got.freed_handle, e.freed_handle));
         if (got.count !== e.count)
            report($sformatf("count %0d, expected %0d", got.count, e.count));
      endtask
   endclass

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   logic [MW-1:0]  req_mode;
   logic [KW-1:0]  req_key;
   logic [HB-1:0]  req_handle;
   logic           req_replace;
   logic [PSW-1:0] req_position;
   logic           rsp_valid;
   logic           rsp_stall;
   logic           rsp_valid_res;
   logic [KW-1:0]  rsp_entry_key;
   logic [HB-1:0]  rsp_entry_handle;
   logic [SW-1:0]  rsp_status;
   logic           rsp_freed;
   logic [HB-1:0]  rsp_freed_handle;
   logic [CW-1:0]  rsp_count;

   table_scoreboard sb = new();
   int  idle_cycles;
   bit  hold_wanted;
   bit  steady_rx;
   int  sent;

   sorted_key_table_with_cursor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_key(req_key), .req_handle(req_handle), .req_replace(req_replace),
      .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_valid_res(rsp_valid_res),
      .rsp_entry_key(rsp_entry_key), .rsp_entry_handle(rsp_entry_handle),
      .rsp_status(rsp_status), .rsp_freed(rsp_freed),
      .rsp_freed_handle(rsp_freed_handle), .rsp_count(rsp_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(logic [MW-1:0] mode, logic [KW-1:0] key,
                            logic [HB-1:0] hdl, logic repl, logic [PSW-1:0] pos);
      int gap;
      gap = $urandom_range(0, 3);
      if (sent % 200 > 150) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_key <= key;
      req_handle <= hdl;
      req_replace <= repl;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      sb.note_request(mode, key, hdl, repl, pos);
      sent++;
   endtask

   function automatic logic [KW-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (sb.entries > 0 && r < 45) return sb.keys[$urandom_range(0, sb.entries - 1)];
      if (sb.entries > 0 && r < 55)
         return sb.keys[$urandom_range(0, sb.entries - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      if (r < 60) return $urandom_range(0, 1) ? '1 : '0;
      return $urandom();
   endfunction

   task automatic random_item();
      int r;
      logic [MW-1:0] m;
      r = $urandom_range(0, 99);
      if (r < 22) m = skt_pkg::MODE_INSERT;
      else if (r < 36) m = skt_pkg::MODE_INSERT_UNIQUE;
      else if (r < (sb.entries > 40 ? 60 : 46)) m = skt_pkg::MODE_REMOVE;
      else if (r < 98) m = MW'($urandom_range(skt_pkg::MODE_FIRST, 15));
      else m = skt_pkg::MODE_CLEAR;
      send_item(m, pick_key(), HB'($urandom()), 1'($urandom_range(0, 1)),
                PSW'($urandom_range(0, 255)));
   endtask

   always begin
      int n;
      outcome_type got;
      n = steady_rx ? 0 : $urandom_range(0, 3);
      if (hold_wanted) begin
         n = LONG_HOLD;
         hold_wanted = 0;
      end
      if (n > 0) begin
         rsp_stall <= 1'b1;
         repeat (n) @(posedge clock);
         rsp_stall <= 1'b0;
      end
      do @(posedge clock); while (!(rsp_valid && !reset));
      got = '{rsp_valid_res, rsp_entry_key, rsp_entry_handle, rsp_status,
              rsp_freed, rsp_freed_handle, rsp_count};
      sb.check_response(got);
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = skt_pkg::MODE_CURRENT;
      req_key = '0;
      req_handle = '0;
      req_replace = 1'b0;
      req_position = '0;
      rsp_stall = 1'b0;
      idle_cycles = 0;
      hold_wanted = 0;
      steady_rx = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(skt_pkg::MODE_CLEAR, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_REMOVE, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_FIRST, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_LAST, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_PREV, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_NEXT, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_SEEK_TO, '0, '0, 0, 8'hFF);
      send_item(skt_pkg::MODE_FIND, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1, 8'hFF);
      send_item(skt_pkg::MODE_INSERT, 32'h0000_0000, 16'h0000, 0, '0);
      send_item(skt_pkg::MODE_INSERT, 32'h1234_5678, 16'h1234, 0, '0);
      send_item(skt_pkg::MODE_INSERT, 32'h1234_5678, 16'h0001, 0, '0);
      send_item(skt_pkg::MODE_INSERT_UNIQUE, 32'h1234_5678, 16'h0002, 0, '0);
      send_item(skt_pkg::MODE_INSERT_UNIQUE, 32'h1234_5678, 16'hAAAA, 1, '0);
      send_item(skt_pkg::MODE_SEEK_TO, '0, '0, 0, 8'hFF);
      send_item(skt_pkg::MODE_NEXT, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_FIRST, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_PREV, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_FIND, 32'hFFFF_FFFF, '0, 0, '0);
      send_item(skt_pkg::MODE_CURRENT, '0, '0, 0, '0);
      send_item(4'd15, '0, '0, 0, '0);
      send_item(4'd11, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_SEEK_TO, '0, '0, 0, 8'h00);
      send_item(skt_pkg::MODE_REMOVE, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_LAST, '0, '0, 0, '0);
      send_item(skt_pkg::MODE_REMOVE, '0, '0, 0, '0);

      for (int i = 0; i < 600; i++) begin
         if (i == 300) hold_wanted = 1;
         steady_rx = (i % 250) > 200;
         random_item();
      end

      send_item(skt_pkg::MODE_CLEAR, '0, '0, 0, '0);
      while (sb.entries < DEPTH)
         send_item($urandom_range(0, 1) ? skt_pkg::MODE_INSERT
                                        : skt_pkg::MODE_INSERT_UNIQUE,
                   $urandom(), HB'($urandom()), 0, '0);
      send_item(skt_pkg::MODE_INSERT, $urandom(), HB'($urandom()), 0, '0);
      send_item(skt_pkg::MODE_INSERT_UNIQUE, sb.keys[0] + 1, HB'($urandom()), 1, '0);
      send_item(skt_pkg::MODE_INSERT_UNIQUE, sb.keys[DEPTH-1], HB'($urandom()), 1, '0);
      send_item(skt_pkg::MODE_INSERT_UNIQUE, sb.keys[100], HB'($urandom()), 0, '0);
      send_item(skt_pkg::MODE_SEEK_TO, '0, '0, 0, 8'hFF);
      send_item(skt_pkg::MODE_NEXT, '0, '0, 0, '0);
      for (int i = 0; i < 40; i++) random_item();
      send_item(skt_pkg::MODE_CLEAR, '0, '0, 0, '0);

      for (int i = 0; i < 500; i++) begin
         steady_rx = (i % 200) < 30;
         random_item();
      end

      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
